FILE: hw/rtl/time_of_day_clock_display_macros.svh
// ----------------------------------------------------------------------------
// Time-of-day clock display assertion macros
// Shared forms for the concurrent checks on the display block's ports.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_DISPLAY_MACROS_SVH
`define TIME_OF_DAY_CLOCK_DISPLAY_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define TODCLK_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("time of day clock display check failed");

// Check that also runs during reset.
`define TODCLK_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("time of day clock display check failed during reset");

`endif

FILE: hw/rtl/todclk_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day clock display package
// Types, constants and helper functions for the clock and its display.
// ----------------------------------------------------------------------------
package todclk_pkg;

   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 72;

   localparam int HOURS_W = 5;
   localparam int COUNT_W = 6;
   localparam int CHAR_W  = 6;
   localparam int LETTER_W = 7;
   localparam int MASK_W  = 3;

   localparam logic [COUNT_W-1:0] SECONDS_RESET = 6'd45;
   localparam logic [COUNT_W-1:0] MINUTES_RESET = 6'd59;
   localparam logic [HOURS_W-1:0] HOURS_RESET   = 5'd11;

   localparam logic [COUNT_W:0] SIXTY_MOD = 7'd60;
   localparam logic [COUNT_W:0] DAY_MOD   = 7'd24;
   localparam logic [HOURS_W-1:0] NOON_HOUR = 5'd12;
   localparam logic [HOURS_W-1:0] MAX_HOUR  = 5'd23;
   localparam logic [COUNT_W-1:0] MAX_COUNT = 6'd59;

   localparam int BTN_SECONDS = 0;
   localparam int BTN_MINUTES = 1;
   localparam int BTN_HOURS   = 2;

   localparam logic [CHAR_W-1:0]   CHAR_ZERO  = 6'h30;
   localparam logic [LETTER_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [LETTER_W-1:0] CHAR_A     = 7'h61;
   localparam logic [LETTER_W-1:0] CHAR_P     = 7'h70;
   localparam logic [LETTER_W-1:0] CHAR_M     = 7'h6d;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SET    = 2'd1,
      OP_TOGGLE = 2'd2
   } opcode_type;

   typedef struct packed {
      logic                changed;
      logic [LETTER_W-1:0] suffix_char;
      logic [LETTER_W-1:0] meridiem_char;
      logic [CHAR_W-1:0]   second_units_char;
      logic [CHAR_W-1:0]   second_tens_char;
      logic [CHAR_W-1:0]   minute_units_char;
      logic [CHAR_W-1:0]   minute_tens_char;
      logic [CHAR_W-1:0]   hour_units_char;
      logic [CHAR_W-1:0]   hour_tens_char;
      logic [COUNT_W-1:0]  seconds_now;
      logic [COUNT_W-1:0]  minutes_now;
      logic [HOURS_W-1:0]  hours_now;
   } result_type;

   // Adds one and wraps to zero at or above the modulus.
   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] value,
                                               input logic [COUNT_W:0] modulus);
      logic [COUNT_W:0] next;
      next = {1'b0, value} + 7'd1;
      return (next >= modulus) ? '0 : next[COUNT_W-1:0];
   endfunction

   function automatic logic [3:0] tens_digit(input logic [COUNT_W-1:0] value);
      logic [3:0] tens;
      if (value >= 6'd60) begin
         tens = 4'd6;
      end else if (value >= 6'd50) begin
         tens = 4'd5;
      end else if (value >= 6'd40) begin
         tens = 4'd4;
      end else if (value >= 6'd30) begin
         tens = 4'd3;
      end else if (value >= 6'd20) begin
         tens = 4'd2;
      end else if (value >= 6'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      return tens;
   endfunction

   function automatic logic [CHAR_W-1:0] tens_char(input logic [COUNT_W-1:0] value);
      return CHAR_ZERO + {2'b00, tens_digit(value)};
   endfunction

   function automatic logic [CHAR_W-1:0] units_char(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] tens_value;
      logic [COUNT_W-1:0] units;
      tens_value = {2'b00, tens_digit(value)} * 6'd10;
      units = value - tens_value;
      return CHAR_ZERO + {2'b00, units[3:0]};
   endfunction

endpackage

FILE: hw/rtl/time_of_day_clock_display.sv
// ----------------------------------------------------------------------------
// Time-of-day clock display
// Hours, minutes and seconds counter with a 12/24-hour ASCII display.
// ----------------------------------------------------------------------------
// Each request item is a command: req_tuser carries the opcode (tick, set
// buttons, toggle format) and req_tdata carries the button mask for set.
// Every accepted item yields exactly one response item with the numeric time,
// the six ASCII digits, the am/pm letters or spaces, and the changed flag.
// The counters update and the display is formatted in the cycle of
// acceptance; the response is then registered into the queue behind any older one.
// One item is accepted per cycle. The response side is a two-entry register
// queue, so a new item is still taken while one finished response waits;
// req_tready drops only when both entries hold responses not yet taken, and
// it depends on registered state only.
// Reset sets the time to 11:59:45 in 24-hour display and empties the queue.
// ----------------------------------------------------------------------------
module time_of_day_clock_display (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] opcode
   input  logic [todclk_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // [2:0] button_mask, [7:3] zero
   input  logic [todclk_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] hours_now, [10:5] minutes_now, [16:11] seconds_now,
   // [22:17] hour_tens_char, [28:23] hour_units_char,
   // [34:29] minute_tens_char, [40:35] minute_units_char,
   // [46:41] second_tens_char, [52:47] second_units_char,
   // [59:53] meridiem_char, [66:60] suffix_char, [67] changed, [71:68] zero
   output logic [todclk_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic [todclk_pkg::COUNT_W-1:0] seconds_ff, seconds_in;
   logic [todclk_pkg::COUNT_W-1:0] minutes_ff, minutes_in;
   logic [todclk_pkg::HOURS_W-1:0] hours_ff, hours_in;
   logic                           twelve_ff, twelve_in;

   todclk_pkg::result_type head_ff, head_in;
   todclk_pkg::result_type tail_ff, tail_in;
   todclk_pkg::result_type result;
   logic [1:0]             count_ff, count_in;

   todclk_pkg::opcode_type      opcode;
   logic [todclk_pkg::MASK_W-1:0] mask;
   logic [todclk_pkg::COUNT_W-1:0] hours_wide;
   logic [todclk_pkg::COUNT_W-1:0] bumped_hours;
   logic [todclk_pkg::HOURS_W-1:0] shown_hour;
   logic                           changed;
   logic                           push;
   logic                           pop;

   assign opcode = todclk_pkg::opcode_type'(req_tuser[1:0]);
   assign mask   = req_tdata[todclk_pkg::MASK_W-1:0];
   assign push   = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   assign hours_wide   = {1'b0, hours_ff};
   assign bumped_hours = todclk_pkg::bump(hours_wide, todclk_pkg::DAY_MOD);

   always_comb begin
      seconds_in = seconds_ff;
      minutes_in = minutes_ff;
      hours_in   = hours_ff;
      twelve_in  = twelve_ff;
      changed    = 1'b0;
      unique case (opcode)
         todclk_pkg::OP_TICK: begin
            seconds_in = todclk_pkg::bump(seconds_ff, todclk_pkg::SIXTY_MOD);
            if (seconds_in == '0) begin
               minutes_in = todclk_pkg::bump(minutes_ff, todclk_pkg::SIXTY_MOD);
               if (minutes_in == '0) begin
                  hours_in = bumped_hours[todclk_pkg::HOURS_W-1:0];
               end
            end
         end
         todclk_pkg::OP_SET: begin
            if (mask[todclk_pkg::BTN_SECONDS]) begin
               seconds_in = todclk_pkg::bump(seconds_ff, todclk_pkg::SIXTY_MOD);
            end
            if (mask[todclk_pkg::BTN_MINUTES]) begin
               minutes_in = todclk_pkg::bump(minutes_ff, todclk_pkg::SIXTY_MOD);
            end
            if (mask[todclk_pkg::BTN_HOURS]) begin
               hours_in = bumped_hours[todclk_pkg::HOURS_W-1:0];
            end
            changed = (mask != '0);
         end
         todclk_pkg::OP_TOGGLE: begin
            twelve_in = !twelve_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      shown_hour = hours_in;
      if (twelve_in) begin
         if (hours_in == '0) begin
            shown_hour = todclk_pkg::NOON_HOUR;
         end else if (hours_in > todclk_pkg::NOON_HOUR) begin
            shown_hour = hours_in - todclk_pkg::NOON_HOUR;
         end
      end
   end

   always_comb begin
      result.hours_now         = hours_in;
      result.minutes_now       = minutes_in;
      result.seconds_now       = seconds_in;
      result.hour_tens_char    = todclk_pkg::tens_char({1'b0, shown_hour});
      result.hour_units_char   = todclk_pkg::units_char({1'b0, shown_hour});
      result.minute_tens_char  = todclk_pkg::tens_char(minutes_in);
      result.minute_units_char = todclk_pkg::units_char(minutes_in);
      result.second_tens_char  = todclk_pkg::tens_char(seconds_in);
      result.second_units_char = todclk_pkg::units_char(seconds_in);
      if (twelve_in) begin
         result.meridiem_char = (hours_in >= todclk_pkg::NOON_HOUR) ?
                                todclk_pkg::CHAR_P : todclk_pkg::CHAR_A;
         result.suffix_char   = todclk_pkg::CHAR_M;
      end else begin
         result.meridiem_char = todclk_pkg::CHAR_SPACE;
         result.suffix_char   = todclk_pkg::CHAR_SPACE;
      end
      result.changed = changed;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push && (count_ff == 2'd0 || (count_ff == 2'd1 && pop))) begin
         head_in = result;
      end else if (pop && count_ff == 2'd2) begin
         head_in = tail_ff;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         tail_in = result;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff <= todclk_pkg::SECONDS_RESET;
         minutes_ff <= todclk_pkg::MINUTES_RESET;
         hours_ff   <= todclk_pkg::HOURS_RESET;
         twelve_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (push) begin
            seconds_ff <= seconds_in;
            minutes_ff <= minutes_in;
            hours_ff   <= hours_in;
            twelve_ff  <= twelve_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign req_tready = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {4'b0000, head_ff};

endmodule

FILE: hw/rtl/todclk_checker.sv
// ----------------------------------------------------------------------------
// Time-of-day clock display checker
// Port-level checks on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_of_day_clock_display_macros.svh"

module todclk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [todclk_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   todclk_pkg::result_type rsp_view;
   logic                   time_ok;
   logic                   letters_ok;

   assign rsp_view = rsp_tdata[$bits(todclk_pkg::result_type)-1:0];
   assign time_ok = (rsp_view.hours_now <= todclk_pkg::MAX_HOUR) &&
                    (rsp_view.minutes_now <= todclk_pkg::MAX_COUNT) &&
                    (rsp_view.seconds_now <= todclk_pkg::MAX_COUNT);
   assign letters_ok = (rsp_view.suffix_char == todclk_pkg::CHAR_SPACE) ==
                       (rsp_view.meridiem_char == todclk_pkg::CHAR_SPACE);

   // A stalled response stays and keeps its contents.
   `TODCLK_ASSERT(stall_holds_a, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   `TODCLK_ASSERT(time_range_a, rsp_tvalid |-> time_ok)

   `TODCLK_ASSERT(format_match_a, rsp_tvalid |-> letters_ok)

   `TODCLK_ASSERT_ALWAYS(empty_after_reset_a, reset |=> !rsp_tvalid && req_tready)

endmodule

bind time_of_day_clock_display todclk_checker u_todclk_checker (.*);
